/* rtl/m2ua_hp_pkg.sv */
// Shared types and constants for the M2UA/MTP3 header parser.
package m2ua_hp_pkg;

   localparam int POS_W       = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   localparam logic [31:0] M2UA_PPID        = 32'd2;
   localparam logic [15:0] IE_PROTOCOL_DATA = 16'h0300;
   localparam logic [3:0]  SI_ISUP          = 4'h5;
   localparam logic [7:0]  M2UA_VERSION     = 8'h01;
   localparam logic [7:0]  M2UA_CLASS       = 8'h06;
   localparam logic [7:0]  M2UA_TYPE        = 8'h01;
   localparam logic [31:0] HEADER_BYTES     = 32'd8;
   localparam logic [15:0] MTP_HEADER_BYTES = 16'd5;

   localparam logic [3:0] V_ISUP      = 4'd0;
   localparam logic [3:0] V_BAD_PPID  = 4'd1;
   localparam logic [3:0] V_SHORT_HDR = 4'd2;
   localparam logic [3:0] V_VERSION   = 4'd3;
   localparam logic [3:0] V_RESERVED  = 4'd4;
   localparam logic [3:0] V_CLASS     = 4'd5;
   localparam logic [3:0] V_TYPE      = 4'd6;
   localparam logic [3:0] V_LENGTH    = 4'd7;
   localparam logic [3:0] V_OVERRUN   = 4'd8;
   localparam logic [3:0] V_PADDING   = 4'd9;
   localparam logic [3:0] V_NO_DATA   = 4'd10;
   localparam logic [3:0] V_MTP_SHORT = 4'd11;
   localparam logic [3:0] V_NOT_ISUP  = 4'd12;
   localparam logic [3:0] V_BAD_IE    = 4'd13;
   localparam logic [3:0] V_TOO_LONG  = 4'd14;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_ELEMENT,
      PH_LABEL,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       ppid_ok;
   } beat_type;

endpackage

/* rtl/m2ua_hp_front.sv */
// Front end: takes request beats, drops strays outside a message, tags the PPID check.
module m2ua_hp_front
   import m2ua_hp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_payload_protocol,
   input  logic        q_full,
   output logic        q_push,
   output beat_type    q_beat
);

   logic open_ff;
   logic open_in;
   logic accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept && (req_first_byte || open_ff);

   assign q_beat.data    = req_msg_byte;
   assign q_beat.first   = req_first_byte;
   assign q_beat.last    = req_last_byte;
   assign q_beat.ppid_ok = (req_payload_protocol == M2UA_PPID);

   always_comb begin
      open_in = open_ff;
      if (accept) begin
         if (req_first_byte) begin
            open_in = !req_last_byte;
         end else if (req_last_byte) begin
            open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
      end
   end

endmodule

/* rtl/m2ua_hp_queue.sv */
// Short FIFO of classified beats between front end and parser.
module m2ua_hp_queue
   import m2ua_hp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  beat_type push_beat,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output beat_type head_beat
);

   beat_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff;
   logic [QUEUE_CW-1:0]   count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_beat  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

/* rtl/m2ua_hp_parse.sv */
// Back end: header check, element walk, routing label capture and result register.
module m2ua_hp_parse
   import m2ua_hp_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = 65535
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  beat_type    head_beat,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_verdict,
   output logic [13:0] rsp_origin_point,
   output logic [13:0] rsp_destination_point,
   output logic [3:0]  rsp_service_indicator,
   output logic [15:0] rsp_payload_offset,
   output logic [15:0] rsp_payload_length
);

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_MESSAGE_BYTES);

   phase_type        phase_ff, phase_in, phase_n, cur_phase;
   logic [POS_W-1:0] pos_ff, pos_in, pos_n, p;
   logic [31:0]      decl_ff, decl_in, decl_n, cur_decl;
   logic [31:0]      rem_ff, rem_in, rem_n;
   logic [15:0]      next_ff, next_in, next_n;
   logic [15:0]      tag_ff, tag_in, tag_n;
   logic [7:0]       iehi_ff, iehi_in, iehi_n;
   logic [15:0]      lstart_ff, lstart_in, lstart_n;
   logic [15:0]      flen_ff, flen_in, flen_n;
   logic [39:0]      label_ff, label_in, label_n, cur_label;
   logic [3:0]       err_ff, err_in, err_n, cur_err;
   logic             ok_ff, ok_in, cur_ok;

   logic             back_ready, take;
   logic [7:0]       b;
   logic [16:0]      p17, s17;
   logic [15:0]      ie;
   logic [16:0]      iep;
   logic [17:0]      nxt;
   logic [2:0]       k;

   logic [3:0]       verdict;
   logic [3:0]       res_verdict;
   logic [13:0]      res_opc, res_dpc;
   logic [3:0]       res_si;
   logic [15:0]      res_off, res_len;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       rsp_verdict_ff;
   logic [13:0]      rsp_opc_ff, rsp_dpc_ff;
   logic [3:0]       rsp_si_ff;
   logic [15:0]      rsp_off_ff, rsp_len_ff;

   assign back_ready = !rsp_valid_ff || !rsp_stall;
   assign pop        = head_valid && back_ready;
   assign take       = pop && (head_beat.first || phase_ff != PH_IDLE);
   assign b          = head_beat.data;

   // one byte step
   always_comb begin
      cur_phase = head_beat.first ? PH_HEADER : phase_ff;
      p         = head_beat.first ? '0 : pos_ff;
      cur_decl  = head_beat.first ? '0 : decl_ff;
      cur_err   = head_beat.first ? V_ISUP : err_ff;
      cur_label = head_beat.first ? '0 : label_ff;

      phase_n  = cur_phase;
      pos_n    = p;
      decl_n   = cur_decl;
      err_n    = cur_err;
      label_n  = cur_label;
      rem_n    = rem_ff;
      next_n   = next_ff;
      tag_n    = tag_ff;
      iehi_n   = iehi_ff;
      lstart_n = lstart_ff;
      flen_n   = flen_ff;

      p17 = {1'b0, p};
      s17 = {1'b0, next_ff};
      ie  = {iehi_ff, b};
      iep = ({1'b0, ie} + 17'd3) & ~17'd3;
      nxt = {2'b0, next_ff} + {1'b0, iep};
      k   = 3'(p - lstart_ff);

      if (p >= MAX_POS) begin
         err_n   = V_TOO_LONG;
         phase_n = PH_DONE;
      end else begin
         pos_n = p + 1'b1;
         unique case (cur_phase)
            PH_HEADER: begin
               if (p == 16'd0 && b != M2UA_VERSION && cur_err == V_ISUP) begin
                  err_n = V_VERSION;
               end
               if (p == 16'd1 && b != 8'd0 && cur_err == V_ISUP) begin
                  err_n = V_RESERVED;
               end
               if (p == 16'd2 && b != M2UA_CLASS && cur_err == V_ISUP) begin
                  err_n = V_CLASS;
               end
               if (p == 16'd3 && b != M2UA_TYPE && cur_err == V_ISUP) begin
                  err_n = V_TYPE;
               end
               if (p >= 16'd4 && p <= 16'd7) begin
                  decl_n = {cur_decl[23:0], b};
               end
               if (p == 16'd7) begin
                  priority if (cur_err != V_ISUP) begin
                     phase_n = PH_DONE;
                  end else if (decl_n < HEADER_BYTES) begin
                     err_n   = V_LENGTH;
                     phase_n = PH_DONE;
                  end else if (decl_n <= HEADER_BYTES + 32'd4) begin
                     err_n   = V_NO_DATA;
                     phase_n = PH_DONE;
                  end else begin
                     next_n  = 16'(HEADER_BYTES);
                     rem_n   = decl_n - HEADER_BYTES;
                     phase_n = PH_ELEMENT;
                  end
               end
            end
            PH_ELEMENT: begin
               if (p17 == s17) begin
                  tag_n[15:8] = b;
               end else if (p17 == s17 + 17'd1) begin
                  tag_n[7:0] = b;
               end else if (p17 == s17 + 17'd2) begin
                  iehi_n = b;
               end else if (p17 == s17 + 17'd3) begin
                  priority if (ie < 16'd4) begin
                     err_n   = V_BAD_IE;
                     phase_n = PH_DONE;
                  end else if ({16'b0, ie} > rem_ff) begin
                     err_n   = V_OVERRUN;
                     phase_n = PH_DONE;
                  end else if (tag_ff == IE_PROTOCOL_DATA) begin
                     if (ie < 16'd4 + MTP_HEADER_BYTES) begin
                        err_n   = V_MTP_SHORT;
                        phase_n = PH_DONE;
                     end else begin
                        lstart_n = next_ff + 16'd4;
                        flen_n   = ie - 16'd4 - MTP_HEADER_BYTES;
                        phase_n  = PH_LABEL;
                     end
                  end else if ({15'b0, iep} > rem_ff) begin
                     err_n   = V_PADDING;
                     phase_n = PH_DONE;
                  end else if ({15'b0, iep} + 32'd4 >= rem_ff) begin
                     err_n   = V_NO_DATA;
                     phase_n = PH_DONE;
                  end else begin
                     next_n = (nxt[17:16] != 2'b0) ? 16'hFFFF : nxt[15:0];
                     rem_n  = rem_ff - {15'b0, iep};
                  end
               end
            end
            PH_LABEL: begin
               unique case (k)
                  3'd0:    label_n[7:0]   = b;
                  3'd1:    label_n[15:8]  = b;
                  3'd2:    label_n[23:16] = b;
                  3'd3:    label_n[31:24] = b;
                  default: label_n[39:32] = b;
               endcase
               if (k == 3'd4) begin
                  err_n   = (cur_label[3:0] == SI_ISUP) ? V_ISUP : V_NOT_ISUP;
                  phase_n = PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // verdict and result fields for a closing beat
   always_comb begin
      cur_ok = head_beat.first ? head_beat.ppid_ok : ok_ff;
      priority if (!cur_ok) begin
         verdict = V_BAD_PPID;
      end else if (err_n == V_TOO_LONG) begin
         verdict = V_TOO_LONG;
      end else if (pos_n < POS_W'(HEADER_BYTES)) begin
         verdict = V_SHORT_HDR;
      end else if (err_n >= V_VERSION && err_n <= V_LENGTH) begin
         verdict = err_n;
      end else if ({16'b0, pos_n} < decl_n) begin
         verdict = V_LENGTH;
      end else if (phase_n == PH_DONE) begin
         verdict = err_n;
      end else begin
         verdict = V_NO_DATA;
      end

      res_verdict = verdict;
      if (verdict == V_ISUP || verdict == V_NOT_ISUP) begin
         res_opc = label_n[35:22];
         res_dpc = label_n[21:8];
         res_si  = label_n[3:0];
         res_off = lstart_ff + MTP_HEADER_BYTES;
         res_len = flen_ff;
      end else begin
         res_opc = '0;
         res_dpc = '0;
         res_si  = '0;
         res_off = '0;
         res_len = '0;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      decl_in   = decl_ff;
      rem_in    = rem_ff;
      next_in   = next_ff;
      tag_in    = tag_ff;
      iehi_in   = iehi_ff;
      lstart_in = lstart_ff;
      flen_in   = flen_ff;
      label_in  = label_ff;
      err_in    = err_ff;
      ok_in     = ok_ff;
      if (take) begin
         phase_in  = head_beat.last ? PH_IDLE : phase_n;
         pos_in    = pos_n;
         decl_in   = decl_n;
         rem_in    = rem_n;
         next_in   = next_n;
         tag_in    = tag_n;
         iehi_in   = iehi_n;
         lstart_in = lstart_n;
         flen_in   = flen_n;
         label_in  = label_n;
         err_in    = err_n;
         ok_in     = cur_ok;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (take && head_beat.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         decl_ff      <= '0;
         err_ff       <= V_ISUP;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         decl_ff      <= decl_in;
         err_ff       <= err_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      next_ff   <= next_in;
      tag_ff    <= tag_in;
      iehi_ff   <= iehi_in;
      lstart_ff <= lstart_in;
      flen_ff   <= flen_in;
      label_ff  <= label_in;
      if (take && head_beat.last) begin
         rsp_verdict_ff <= res_verdict;
         rsp_opc_ff     <= res_opc;
         rsp_dpc_ff     <= res_dpc;
         rsp_si_ff      <= res_si;
         rsp_off_ff     <= res_off;
         rsp_len_ff     <= res_len;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_verdict           = rsp_verdict_ff;
   assign rsp_origin_point      = rsp_opc_ff;
   assign rsp_destination_point = rsp_dpc_ff;
   assign rsp_service_indicator = rsp_si_ff;
   assign rsp_payload_offset    = rsp_off_ff;
   assign rsp_payload_length    = rsp_len_ff;

endmodule

/* rtl/m2ua_hp_m2ua_mtp3_isup_header_parser.sv */
// Top level of the M2UA/MTP3 ISUP header parser.
module m2ua_mtp3_isup_header_parser
   import m2ua_hp_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = 65535
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_first_byte,
   input  logic        req_last_byte,
   input  logic [31:0] req_payload_protocol,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_verdict,
   output logic [13:0] rsp_origin_point,
   output logic [13:0] rsp_destination_point,
   output logic [3:0]  rsp_service_indicator,
   output logic [15:0] rsp_payload_offset,
   output logic [15:0] rsp_payload_length
);

   logic     q_full;
   logic     q_push;
   beat_type q_beat;
   logic     q_pop;
   logic     q_valid;
   beat_type q_head;

   m2ua_hp_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_msg_byte         (req_msg_byte),
      .req_first_byte       (req_first_byte),
      .req_last_byte        (req_last_byte),
      .req_payload_protocol (req_payload_protocol),
      .q_full               (q_full),
      .q_push               (q_push),
      .q_beat               (q_beat)
   );

   m2ua_hp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_beat  (q_beat),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_beat  (q_head)
   );

   m2ua_hp_parse #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_parse (
      .clock                 (clock),
      .reset                 (reset),
      .head_valid            (q_valid),
      .head_beat             (q_head),
      .pop                   (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_verdict           (rsp_verdict),
      .rsp_origin_point      (rsp_origin_point),
      .rsp_destination_point (rsp_destination_point),
      .rsp_service_indicator (rsp_service_indicator),
      .rsp_payload_offset    (rsp_payload_offset),
      .rsp_payload_length    (rsp_payload_length)
   );

endmodule
